FILE: rtl/stereo_compressor_gain_ramp_top_macros.svh
// Assertion helpers shared by the RTL. Every property is clocked on clk and
// is switched off while arst_n is low.
`ifndef STEREO_COMPRESSOR_GAIN_RAMP_TOP_MACROS_SVH
`define STEREO_COMPRESSOR_GAIN_RAMP_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCGR_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SCGR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/scgr_pkg.sv
package scgr_pkg;

	// Gain format: unsigned Q2.FRAC.
	localparam int FRAC       = 24;
	localparam int GAIN_W     = FRAC + 2;
	localparam int DIFF_W     = FRAC + 1;
	localparam int SAMP_W     = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 18;

	// Step division: (diff * 1000) / (ms * rate).
	localparam int STEP_SCALE = 1000;
	localparam int SCALE_W    = 10;
	localparam int NUM_W      = DIFF_W + SCALE_W;
	localparam int DEN_W      = 26;
	localparam int CNT_W      = $clog2(NUM_W);

	// Shared multiplier operands and product.
	localparam int MA_W = GAIN_W + SAMP_W;
	localparam int MB_W = SAMP_W;
	localparam int P_W  = MA_W + MB_W;

	// Output scaling shift: gain fraction plus the makeup divisor of 64.
	localparam int SH      = FRAC + 6;
	localparam int SAT_NEG = 32768;
	localparam int SAT_POS = 32767;
	localparam int MAKEUP_BASE = 64;

	localparam logic [GAIN_W-1:0] ONE_G  = GAIN_W'(1) << FRAC;
	localparam logic [P_W-1:0]    HALF_P = P_W'(1) << (SH - 1);
	localparam logic [MB_W-1:0]   STEP_MUL = MB_W'(STEP_SCALE);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_INPUT_GAIN = 3'd0,
		CFG_THRESHOLD  = 3'd1,
		CFG_RATIO      = 3'd2,
		CFG_ATTACK     = 3'd3,
		CFG_RELEASE    = 3'd4,
		CFG_RATE       = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		RAMP_NONE    = 2'd0,
		RAMP_ATTACK  = 2'd1,
		RAMP_RELEASE = 2'd2
	} ramp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LEVEL,
		ST_DEN,
		ST_NUM,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_STEP,
		ST_GAIN,
		ST_MUL_L,
		ST_MUL_R,
		ST_MAKEUP_L,
		ST_MAKEUP_R,
		ST_ROUND_R,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [MA_W-1:0] a;
		logic [MB_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [NUM_W-1:0] quo;
	} div_rsp_t;

	// Gain floor for a compression ratio of 1:(r+1).
	function automatic logic [GAIN_W-1:0] gain_target(input logic [4:0] r);
		logic [GAIN_W-1:0] t;
		case (r)
			5'd1:    t = ONE_G / 2;
			5'd2:    t = ONE_G / 3;
			5'd3:    t = ONE_G / 4;
			5'd4:    t = ONE_G / 5;
			5'd5:    t = ONE_G / 6;
			5'd6:    t = ONE_G / 7;
			5'd7:    t = ONE_G / 8;
			5'd8:    t = ONE_G / 9;
			5'd9:    t = ONE_G / 10;
			5'd10:   t = ONE_G / 11;
			5'd11:   t = ONE_G / 12;
			5'd12:   t = ONE_G / 13;
			5'd13:   t = ONE_G / 14;
			5'd14:   t = ONE_G / 15;
			5'd15:   t = ONE_G / 16;
			default: t = ONE_G;
		endcase
		return t;
	endfunction

	function automatic logic [SAMP_W-1:0] magnitude(input logic [SAMP_W-1:0] s);
		return s[SAMP_W-1] ? (~s + SAMP_W'(1)) : s;
	endfunction

	// Round half away from zero on the magnitude, restore the sign, saturate.
	function automatic logic [SAMP_W-1:0] round_sat(input logic [P_W-1:0] p,
		input logic neg);
		logic [P_W-1:0]    sum;
		logic [P_W-1:0]    r;
		logic [SAMP_W-1:0] m;
		logic [SAMP_W-1:0] res;
		sum = p + HALF_P;
		r   = sum >> SH;
		if (neg) begin
			if (r > P_W'(SAT_NEG)) begin
				m = SAMP_W'(SAT_NEG);
			end else begin
				m = r[SAMP_W-1:0];
			end
			res = ~m + SAMP_W'(1);
		end else begin
			if (r > P_W'(SAT_POS)) begin
				res = SAMP_W'(SAT_POS);
			end else begin
				res = r[SAMP_W-1:0];
			end
		end
		return res;
	endfunction

endpackage

FILE: rtl/scgr_mul.sv
// Shared multiplier with a registered product.
module scgr_mul (
	input  logic                   clk,
	input  scgr_pkg::mul_req_t     req,
	output logic [scgr_pkg::P_W-1:0] p
);

	logic [scgr_pkg::P_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= scgr_pkg::P_W'(req.a) * scgr_pkg::P_W'(req.b);
	end

	assign p = p_q;

endmodule

FILE: rtl/scgr_div.sv
// Restoring divider, one quotient bit per cycle. The quotient is valid
// when done pulses and holds until the next start.
module scgr_div (
	input  logic               clk,
	input  logic               arst_n,
	input  scgr_pkg::div_req_t req,
	output scgr_pkg::div_rsp_t rsp
);

	logic                         busy_q;
	logic                         done_q;
	logic [scgr_pkg::CNT_W-1:0]   cnt_q;
	logic [scgr_pkg::DEN_W-1:0]   rem_q;
	logic [scgr_pkg::DEN_W-1:0]   den_q;
	logic [scgr_pkg::NUM_W-1:0]   quo_q;
	logic [scgr_pkg::DEN_W:0]     trial;
	logic                         fits;
	logic                         last;

	assign trial = {rem_q, quo_q[scgr_pkg::NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};
	assign last  = cnt_q == scgr_pkg::CNT_W'(scgr_pkg::NUM_W - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + scgr_pkg::CNT_W'(1);
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			den_q <= req.den;
			quo_q <= req.num;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= scgr_pkg::DEN_W'(trial - {1'b0, den_q});
			end else begin
				rem_q <= trial[scgr_pkg::DEN_W-1:0];
			end
			quo_q <= {quo_q[scgr_pkg::NUM_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

FILE: rtl/stereo_compressor_gain_ramp_top.sv
// Channel   Direction  Handshake            Payload
// in        input      in_valid/in_stall    left_sample, right_sample
// out       output     out_valid/out_stall  left_out, right_out
// cfg       input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A bypassed word goes straight to the output state; a compressed word takes
// the gain update in a ramp, then channel and makeup products and rounding;
// a ramp start adds the divider, one quotient bit per cycle over 35 bits,
// unless ramp time or rate is zero. A new word waits for the last to leave.
// Reset is asynchronous and active low and restores the settings, the control
// state and unity gain. A stalled result holds the block in its output state.

`include "stereo_compressor_gain_ramp_top_macros.svh"

module stereo_compressor_gain_ramp_top (
	input  logic                                 clk,
	input  logic                                 arst_n,

	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [scgr_pkg::SAMP_W-1:0]   left_sample,
	input  logic signed [scgr_pkg::SAMP_W-1:0]   right_sample,

	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [scgr_pkg::SAMP_W-1:0]   left_out,
	output logic signed [scgr_pkg::SAMP_W-1:0]   right_out,

	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [scgr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [scgr_pkg::CFG_DATA_W-1:0]      cfg_data
);

	// Configuration registers.
	logic [7:0]                       input_gain_q;
	logic [7:0]                       threshold_q;
	logic [4:0]                       ratio_q;
	logic [7:0]                       attack_q;
	logic [7:0]                       release_q;
	logic [scgr_pkg::CFG_DATA_W-1:0]  rate_q;

	// Gain state carried from word to word.
	logic [scgr_pkg::GAIN_W-1:0]      gain_q;
	logic [scgr_pkg::DIFF_W-1:0]      gain_step_q;
	scgr_pkg::ramp_t                  ramp_q;

	// Per-word working registers.
	scgr_pkg::state_t                 state_q;
	scgr_pkg::state_t                 state_d;
	logic [scgr_pkg::SAMP_W-1:0]      l_q;
	logic [scgr_pkg::SAMP_W-1:0]      r_q;
	logic                             above_q;
	logic [scgr_pkg::GAIN_W-1:0]      target_q;
	logic [scgr_pkg::DIFF_W-1:0]      diff_q;
	logic [scgr_pkg::DEN_W-1:0]       den_q;
	logic [scgr_pkg::MA_W-1:0]        pl_q;
	logic [scgr_pkg::MA_W-1:0]        pr_q;
	logic [scgr_pkg::SAMP_W-1:0]      res_l_q;
	logic [scgr_pkg::SAMP_W-1:0]      res_r_q;

	// Output register.
	logic                             out_valid_q;
	logic [scgr_pkg::SAMP_W-1:0]      lo_q;
	logic [scgr_pkg::SAMP_W-1:0]      ro_q;

	// Shared units.
	scgr_pkg::mul_req_t               mul_req;
	logic [scgr_pkg::P_W-1:0]         mul_p;
	scgr_pkg::div_req_t               div_req;
	scgr_pkg::div_rsp_t               div_rsp;

	// Level decision and step clamping.
	logic                             in_take;
	logic                             out_free;
	logic                             bypass;
	logic [scgr_pkg::SAMP_W:0]        level_sum;
	logic [scgr_pkg::SAMP_W:0]        level_thr;
	logic                             above;
	logic                             below_one;
	logic [7:0]                       ramp_ms;
	logic [scgr_pkg::MB_W-1:0]        makeup;
	logic [scgr_pkg::DIFF_W-1:0]      new_step;
	logic [scgr_pkg::GAIN_W-1:0]      gap;
	logic [scgr_pkg::GAIN_W-1:0]      step_wide;

	assign in_take   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign cfg_ready = state_q == scgr_pkg::ST_IDLE;

	// Ratio 0 bypasses, and ratios of 16 and above pass the word unchanged.
	assign bypass    = (ratio_q == 5'd0) || ratio_q[4];
	assign level_sum = {1'b0, scgr_pkg::magnitude(l_q)} + {1'b0, scgr_pkg::magnitude(r_q)};
	assign level_thr = {threshold_q, 9'd0};
	assign above     = level_sum > level_thr;
	assign below_one = gain_q < scgr_pkg::ONE_G;
	assign ramp_ms   = above_q ? attack_q : release_q;
	assign makeup    = scgr_pkg::MB_W'({1'b0, input_gain_q} + 9'(scgr_pkg::MAKEUP_BASE));
	assign step_wide = scgr_pkg::GAIN_W'(gain_step_q);

	// The step is the full distance when the ramp time or the rate is zero; otherwise the
	// quotient is raised to at least one and cut to the full distance.
	always_comb begin
		if (den_q == '0) begin
			new_step = diff_q;
		end else if (div_rsp.quo == '0) begin
			new_step = scgr_pkg::DIFF_W'(1);
		end else if (div_rsp.quo > scgr_pkg::NUM_W'(diff_q)) begin
			new_step = diff_q;
		end else begin
			new_step = div_rsp.quo[scgr_pkg::DIFF_W-1:0];
		end
	end

	// Distance to the end of the current ramp.
	always_comb begin
		if (above_q) begin
			gap = gain_q - target_q;
		end else begin
			gap = scgr_pkg::ONE_G - gain_q;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			scgr_pkg::ST_IDLE: begin
				if (in_take) begin
					state_d = scgr_pkg::ST_LEVEL;
				end
			end
			scgr_pkg::ST_LEVEL: begin
				if (bypass) begin
					state_d = scgr_pkg::ST_OUT;
				end else if (above) begin
					state_d = (ramp_q != scgr_pkg::RAMP_ATTACK) ?
						scgr_pkg::ST_DEN : scgr_pkg::ST_GAIN;
				end else if (below_one) begin
					state_d = (ramp_q != scgr_pkg::RAMP_RELEASE) ?
						scgr_pkg::ST_DEN : scgr_pkg::ST_GAIN;
				end else begin
					state_d = scgr_pkg::ST_MUL_L;
				end
			end
			scgr_pkg::ST_DEN:      state_d = scgr_pkg::ST_NUM;
			scgr_pkg::ST_NUM:      state_d = scgr_pkg::ST_DIV_GO;
			scgr_pkg::ST_DIV_GO: begin
				state_d = (den_q == '0) ? scgr_pkg::ST_STEP : scgr_pkg::ST_DIV_WAIT;
			end
			scgr_pkg::ST_DIV_WAIT: begin
				if (div_rsp.done) begin
					state_d = scgr_pkg::ST_STEP;
				end
			end
			scgr_pkg::ST_STEP:     state_d = scgr_pkg::ST_GAIN;
			scgr_pkg::ST_GAIN:     state_d = scgr_pkg::ST_MUL_L;
			scgr_pkg::ST_MUL_L:    state_d = scgr_pkg::ST_MUL_R;
			scgr_pkg::ST_MUL_R:    state_d = scgr_pkg::ST_MAKEUP_L;
			scgr_pkg::ST_MAKEUP_L: state_d = scgr_pkg::ST_MAKEUP_R;
			scgr_pkg::ST_MAKEUP_R: state_d = scgr_pkg::ST_ROUND_R;
			scgr_pkg::ST_ROUND_R:  state_d = scgr_pkg::ST_OUT;
			scgr_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = scgr_pkg::ST_IDLE;
				end
			end
			default:               state_d = scgr_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs: handshake and the operands of the shared units.
	always_comb begin
		in_stall      = state_q != scgr_pkg::ST_IDLE;
		mul_req       = '0;
		div_req       = '0;
		div_req.num   = mul_p[scgr_pkg::NUM_W-1:0];
		div_req.den   = den_q;
		case (state_q)
			scgr_pkg::ST_DEN: begin
				mul_req.a = scgr_pkg::MA_W'(rate_q);
				mul_req.b = scgr_pkg::MB_W'(ramp_ms);
			end
			scgr_pkg::ST_NUM: begin
				mul_req.a = scgr_pkg::MA_W'(diff_q);
				mul_req.b = scgr_pkg::STEP_MUL;
			end
			scgr_pkg::ST_DIV_GO: begin
				div_req.start = den_q != '0;
			end
			scgr_pkg::ST_MUL_L: begin
				mul_req.a = scgr_pkg::MA_W'(gain_q);
				mul_req.b = scgr_pkg::magnitude(l_q);
			end
			scgr_pkg::ST_MUL_R: begin
				mul_req.a = scgr_pkg::MA_W'(gain_q);
				mul_req.b = scgr_pkg::magnitude(r_q);
			end
			scgr_pkg::ST_MAKEUP_L: begin
				mul_req.a = pl_q;
				mul_req.b = makeup;
			end
			scgr_pkg::ST_MAKEUP_R: begin
				mul_req.a = pr_q;
				mul_req.b = makeup;
			end
			default: begin
				mul_req = '0;
			end
		endcase
	end

	// Control and gain state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= scgr_pkg::ST_IDLE;
			out_valid_q  <= 1'b0;
			input_gain_q <= 8'd0;
			threshold_q  <= 8'd64;
			ratio_q      <= 5'd16;
			attack_q     <= 8'd6;
			release_q    <= 8'd44;
			rate_q       <= scgr_pkg::CFG_DATA_W'(44100);
			gain_q       <= scgr_pkg::ONE_G;
			gain_step_q  <= '0;
			ramp_q       <= scgr_pkg::RAMP_NONE;
		end else begin
			state_q <= state_d;

			if (state_q == scgr_pkg::ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					scgr_pkg::CFG_INPUT_GAIN: input_gain_q <= cfg_data[7:0];
					scgr_pkg::CFG_THRESHOLD:  threshold_q  <= cfg_data[7:0];
					scgr_pkg::CFG_RATIO:      ratio_q      <= cfg_data[4:0];
					scgr_pkg::CFG_ATTACK:     attack_q     <= cfg_data[7:0];
					scgr_pkg::CFG_RELEASE:    release_q    <= cfg_data[7:0];
					scgr_pkg::CFG_RATE:       rate_q       <= cfg_data;
					default: begin
					end
				endcase
			end

			if (state_q == scgr_pkg::ST_STEP) begin
				gain_step_q <= new_step;
				ramp_q      <= above_q ? scgr_pkg::RAMP_ATTACK : scgr_pkg::RAMP_RELEASE;
			end

			// The attack stops at the target and the release at unity; an
			// attack that starts at or below the target leaves the gain alone.
			if (state_q == scgr_pkg::ST_GAIN) begin
				if (above_q) begin
					if (gain_q > target_q) begin
						gain_q <= (gap > step_wide) ? (gain_q - step_wide) : target_q;
					end
				end else begin
					gain_q <= (gap > step_wide) ? (gain_q + step_wide) : scgr_pkg::ONE_G;
				end
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_take) begin
			l_q <= left_sample;
			r_q <= right_sample;
		end
		if (state_q == scgr_pkg::ST_LEVEL) begin
			above_q  <= above;
			target_q <= scgr_pkg::gain_target(ratio_q);
			diff_q   <= scgr_pkg::DIFF_W'(scgr_pkg::ONE_G - scgr_pkg::gain_target(ratio_q));
			res_l_q  <= l_q;
			res_r_q  <= r_q;
		end
		if (state_q == scgr_pkg::ST_NUM) begin
			den_q <= mul_p[scgr_pkg::DEN_W-1:0];
		end
		if (state_q == scgr_pkg::ST_MUL_R) begin
			pl_q <= mul_p[scgr_pkg::MA_W-1:0];
		end
		if (state_q == scgr_pkg::ST_MAKEUP_L) begin
			pr_q <= mul_p[scgr_pkg::MA_W-1:0];
		end
		if (state_q == scgr_pkg::ST_MAKEUP_R) begin
			res_l_q <= scgr_pkg::round_sat(mul_p, l_q[scgr_pkg::SAMP_W-1]);
		end
		if (state_q == scgr_pkg::ST_ROUND_R) begin
			res_r_q <= scgr_pkg::round_sat(mul_p, r_q[scgr_pkg::SAMP_W-1]);
		end
		if (state_q == scgr_pkg::ST_OUT && out_free) begin
			lo_q <= res_l_q;
			ro_q <= res_r_q;
		end
	end

	scgr_mul u_mul (
		.clk (clk),
		.req (mul_req),
		.p   (mul_p)
	);

	scgr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign out_valid = out_valid_q;
	assign left_out  = lo_q;
	assign right_out = ro_q;

	// The gain never ramps above unity.
	`SCGR_ASSERT_SAME(a_gain_max, 1'b1, gain_q <= scgr_pkg::ONE_G, "gain above unity")
	// Once a ramp is under way its step is never zero, so the ramp always moves.
	`SCGR_ASSERT_SAME(a_step_nonzero, ramp_q != scgr_pkg::RAMP_NONE, gain_step_q != '0,
		"zero gain step during a ramp")
	// An accepted word always goes straight to the level decision.
	`SCGR_ASSERT_NEXT(a_accept_level, in_take, state_q == scgr_pkg::ST_LEVEL,
		"accepted word not sequenced")
	// A finished word is presented as soon as the output register is free.
	`SCGR_ASSERT_NEXT(a_out_load, state_q == scgr_pkg::ST_OUT && out_free,
		out_valid_q && state_q == scgr_pkg::ST_IDLE, "result not loaded")

endmodule

FILE: dv/scgr_compressor_checker.sv
module scgr_compressor_checker import scgr_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,

	input  logic                      in_valid,
	input  logic                      in_stall,
	input  logic signed [SAMP_W-1:0]  left_sample,
	input  logic signed [SAMP_W-1:0]  right_sample,

	input  logic                      out_valid,
	input  logic                      out_stall,
	input  logic signed [SAMP_W-1:0]  left_out,
	input  logic signed [SAMP_W-1:0]  right_out,

	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,

	output int                        mismatch_count,
	output int                        results_seen,
	output int                        ramp_starts
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [SAMP_W-1:0] left;
		logic signed [SAMP_W-1:0] right;
	} stereo_pair_t;

	localparam logic [63:0] UNITY         = 64'd1 << FRAC;
	localparam int          LIMITER_RATIO = 16;
	localparam int          THRESH_SCALE  = 512;

	logic [7:0]        makeup_code;
	logic [7:0]        thresh_code;
	logic [4:0]        ratio_code;
	logic [7:0]        attack_len;
	logic [7:0]        release_len;
	logic [17:0]       rate_hz;
	logic [GAIN_W-1:0] gain_q;
	logic [DIFF_W-1:0] step_q;
	ramp_t             ramp_dir;
	stereo_pair_t      scaled_pairs_due[$];
	stereo_pair_t      due;
	int                fails = 0;

	assign mismatch_count = fails;

	function automatic logic [16:0] abs_sample(input logic [SAMP_W-1:0] s);
		return s[SAMP_W-1] ? 17'h10000 - 17'(s) : 17'(s);
	endfunction

	// A ramp step is the gain span spread over the ramp length in samples.
	function automatic logic [63:0] ramp_increment(input logic [63:0] span,
		input logic [7:0] ms, input logic [17:0] rate);
		logic [63:0] den;
		logic [63:0] inc;
		den = 64'(ms) * 64'(rate);
		if (den == 0) begin
			return span;
		end
		inc = span * 64'(STEP_SCALE) / den;
		if (inc == 0) begin
			inc = 1;
		end
		if (inc > span) begin
			inc = span;
		end
		return inc;
	endfunction

	function automatic logic [SAMP_W-1:0] apply_gain(input logic [SAMP_W-1:0] s,
		input logic [63:0] mult);
		logic [63:0] rounded;
		rounded = (64'(abs_sample(s)) * mult + (64'd1 << (SH - 1))) >> SH;
		if (s[SAMP_W-1]) begin
			if (rounded > 64'(SAT_NEG)) begin
				rounded = 64'(SAT_NEG);
			end
			return SAMP_W'(64'h10000 - rounded);
		end
		if (rounded > 64'(SAT_POS)) begin
			rounded = 64'(SAT_POS);
		end
		return SAMP_W'(rounded);
	endfunction

	task automatic compress_pair(input logic [SAMP_W-1:0] l, input logic [SAMP_W-1:0] r);
		logic [63:0]  floor_g;
		logic [63:0]  span;
		logic [63:0]  mult;
		stereo_pair_t res;
		res = '{left: l, right: r};
		if (ratio_code != 0 && ratio_code < LIMITER_RATIO) begin
			floor_g = UNITY / (64'd1 + 64'(ratio_code));
			span    = UNITY - floor_g;
			if (64'(abs_sample(l)) + 64'(abs_sample(r)) > 64'(thresh_code) * THRESH_SCALE) begin
				if (ramp_dir != RAMP_ATTACK) begin
					step_q   = DIFF_W'(ramp_increment(span, attack_len, rate_hz));
					ramp_dir = RAMP_ATTACK;
					ramp_starts++;
				end
				if (gain_q > floor_g) begin
					gain_q = (gain_q - floor_g > step_q) ? gain_q - step_q : GAIN_W'(floor_g);
				end
			end else if (gain_q < UNITY) begin
				if (ramp_dir != RAMP_RELEASE) begin
					step_q   = DIFF_W'(ramp_increment(span, release_len, rate_hz));
					ramp_dir = RAMP_RELEASE;
					ramp_starts++;
				end
				gain_q = (UNITY - gain_q > step_q) ? gain_q + step_q : GAIN_W'(UNITY);
			end
			mult      = 64'(gain_q) * (64'(MAKEUP_BASE) + 64'(makeup_code));
			res.left  = apply_gain(l, mult);
			res.right = apply_gain(r, mult);
		end
		scaled_pairs_due.push_back(res);
	endtask

	task automatic report_mismatch(input string what);
		$display("%0t ns: mismatch: %s", $time, what);
		fails++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			makeup_code  = 8'd0;
			thresh_code  = 8'd64;
			ratio_code   = 5'd16;
			attack_len   = 8'd6;
			release_len  = 8'd44;
			rate_hz      = 18'd44100;
			gain_q       = GAIN_W'(UNITY);
			step_q       = '0;
			ramp_dir     = RAMP_NONE;
			ramp_starts  = 0;
			results_seen <= 0;
			scaled_pairs_due.delete();
		end else begin
			if (out_valid && !out_stall) begin
				results_seen <= results_seen + 1;
				if (scaled_pairs_due.size() == 0) begin
					report_mismatch($sformatf("word L=%0d R=%0d with nothing outstanding",
						left_out, right_out));
				end else begin
					due = scaled_pairs_due.pop_front();
					if (left_out !== due.left) begin
						report_mismatch($sformatf("left_out %0d, predicted %0d", left_out, due.left));
					end
					if (right_out !== due.right) begin
						report_mismatch($sformatf("right_out %0d, predicted %0d", right_out,
							due.right));
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_INPUT_GAIN: makeup_code = cfg_data[7:0];
					CFG_THRESHOLD:  thresh_code = cfg_data[7:0];
					CFG_RATIO:      ratio_code  = cfg_data[4:0];
					CFG_ATTACK:     attack_len  = cfg_data[7:0];
					CFG_RELEASE:    release_len = cfg_data[7:0];
					CFG_RATE:       rate_hz     = cfg_data[17:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				compress_pair(left_sample, right_sample);
			end
		end
	end

endmodule

FILE: dv/tb_stereo_compressor_gain_ramp_top.sv
module tb_stereo_compressor_gain_ramp_top;
	timeunit 1ns;
	timeprecision 1ps;

	import scgr_pkg::*;

	// Half of the 12 ns clock period.
	localparam int CLK_HALF = 6;

	// Indexes beyond the register file; the block must ignore writes to them.
	localparam logic [CFG_IDX_W-1:0] SPARE_REG_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] SPARE_REG_HI = 3'd7;

	// Number of random register settings and sample pairs under each of them.
	localparam int RANDOM_SETTINGS = 12;
	localparam int PAIRS_PER_SETTING = 71;

	// Cycles allowed after the last result for a late or spurious word to show.
	localparam int TAIL_CYCLES = 64;

	typedef struct packed {
		logic [7:0]  makeup;
		logic [7:0]  thresh;
		logic [4:0]  ratio;
		logic [7:0]  attack_ms;
		logic [7:0]  release_ms;
		logic [17:0] rate_hz;
	} comp_settings_t;

	typedef enum logic [1:0] {
		BURST_LOUD,
		BURST_QUIET,
		BURST_NEAR,
		BURST_NOISE
	} burst_kind_t;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_stall;
	logic signed [SAMP_W-1:0]  left_sample;
	logic signed [SAMP_W-1:0]  right_sample;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic signed [SAMP_W-1:0]  left_out;
	logic signed [SAMP_W-1:0]  right_out;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CFG_IDX_W-1:0]      cfg_index;
	logic [CFG_DATA_W-1:0]     cfg_data;

	int             mismatch_count;
	int             results_seen;
	int             ramp_starts;
	int             pairs_sent = 0;
	int             setting_count = 0;
	int             send_gap_pct = 0;
	int             stall_pct = 0;
	comp_settings_t cur;

	stereo_compressor_gain_ramp_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.left_sample  (left_sample),
		.right_sample (right_sample),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.left_out     (left_out),
		.right_out    (right_out),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// The checker watches all three channels, keeps its own model of the gain
	// ramp and compares each result word with its prediction.
	scgr_compressor_checker u_checker (.*);

	always #CLK_HALF clk = ~clk;

	// The receiver holds off results at random, at whatever rate is current.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Hard stop in case the block hangs or loses a word.
	initial begin
		#10_000_000;
		$display("stereo_compressor_gain_ramp_top regression: fail");
		$finish;
	end

	function automatic comp_settings_t settings_of(input int makeup, input int thresh,
		input int ratio, input int attack_ms, input int release_ms, input int rate_hz);
		comp_settings_t s;
		s.makeup     = 8'(makeup);
		s.thresh     = 8'(thresh);
		s.ratio      = 5'(ratio);
		s.attack_ms  = 8'(attack_ms);
		s.release_ms = 8'(release_ms);
		s.rate_hz    = 18'(rate_hz);
		return s;
	endfunction

	// Random settings lean towards short ramps and low sample rates, so that
	// both attack and release run to their ends within a few dozen words. Special values of the
	// makeup, threshold, ratio and rate registers turn up now and then.
	function automatic comp_settings_t random_settings();
		comp_settings_t s;
		case ($urandom_range(3))
			0: s.makeup = 8'd0;
			1: s.makeup = 8'd128;
			default: s.makeup = 8'($urandom_range(128));
		endcase
		case ($urandom_range(7))
			0: s.thresh = 8'd0;
			1: s.thresh = 8'd128;
			default: s.thresh = 8'($urandom_range(8, 96));
		endcase
		case ($urandom_range(9))
			0: s.ratio = 5'd0;
			1: s.ratio = 5'd16;
			default: s.ratio = 5'($urandom_range(1, 15));
		endcase
		s.attack_ms  = ($urandom_range(4) == 0) ? 8'($urandom_range(128)) : 8'($urandom_range(3));
		s.release_ms = ($urandom_range(4) == 0) ? 8'($urandom_range(128)) : 8'($urandom_range(3));
		case ($urandom_range(5))
			0: s.rate_hz = 18'd8000;
			1: s.rate_hz = 18'd192000;
			default: s.rate_hz = 18'($urandom_range(8000, 24000));
		endcase
		return s;
	endfunction

	// Turns a magnitude into a sample of random sign; full scale can only be
	// reached on the negative side.
	function automatic logic signed [SAMP_W-1:0] signed_of(input int unsigned mag);
		if (mag >= 32768) begin
			return 16'sh8000;
		end
		return ($urandom_range(1) != 0) ? SAMP_W'(-int'(mag)) : SAMP_W'(mag);
	endfunction

	// Presents one stereo word, after an optional run of idle cycles, and
	// returns at the edge where the block takes it. Valid stays high on return,
	// so the caller either presents the next word or drops valid itself.
	task automatic send_pair(input logic signed [SAMP_W-1:0] l,
		input logic signed [SAMP_W-1:0] r);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		left_sample  <= l;
		right_sample <= r;
		do @(posedge clk); while (in_stall);
		pairs_sent++;
	endtask

	// Drops valid and waits until every word sent has come back.
	task automatic drain();
		in_valid <= 1'b0;
		while (results_seen != pairs_sent) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Registers are only ever written with the block empty. Valid on the
	// register port stays high across the whole batch and drops at its end.
	task automatic apply_settings(input comp_settings_t s, input bit poke_spares);
		drain();
		if (poke_spares) begin
			write_reg(SPARE_REG_LO, '1);
			write_reg(SPARE_REG_HI, 18'h15a5a);
		end
		write_reg(CFG_INPUT_GAIN, CFG_DATA_W'(s.makeup));
		write_reg(CFG_THRESHOLD, CFG_DATA_W'(s.thresh));
		write_reg(CFG_RATIO, CFG_DATA_W'(s.ratio));
		write_reg(CFG_ATTACK, CFG_DATA_W'(s.attack_ms));
		write_reg(CFG_RELEASE, CFG_DATA_W'(s.release_ms));
		write_reg(CFG_RATE, CFG_DATA_W'(s.rate_hz));
		cfg_valid <= 1'b0;
		cur = s;
		setting_count++;
	endtask

	// A burst is a run of words of one kind: loud ones drive the attack ramp,
	// quiet ones the release, near ones sit within two counts of the
	// threshold and noise words exercise every bit of both samples. The run
	// never goes beyond the number of words still wanted.
	task automatic random_burst(input int unsigned max_len);
		burst_kind_t kind;
		int unsigned len;
		int unsigned quiet_max;
		int          total;
		int unsigned al;
		kind      = burst_kind_t'($urandom_range(3));
		len       = $urandom_range(1, 40);
		if (len > max_len) begin
			len = max_len;
		end
		quiet_max = cur.thresh * 256;
		repeat (len) begin
			case (kind)
				BURST_LOUD: begin
					send_pair(signed_of($urandom_range(quiet_max, 32768)),
						signed_of($urandom_range(quiet_max, 32768)));
				end
				BURST_QUIET: begin
					send_pair(signed_of($urandom_range(0, quiet_max)),
						signed_of($urandom_range(0, quiet_max)));
				end
				BURST_NEAR: begin
					total = int'(cur.thresh) * 512 + int'($urandom_range(4)) - 2;
					if (total < 0) begin
						total = 0;
					end
					if (total > 65536) begin
						total = 65536;
					end
					al = $urandom_range((total > 32768) ? total - 32768 : 0,
						(total < 32768) ? total : 32768);
					send_pair(signed_of(al), signed_of(total - al));
				end
				default: begin
					send_pair(SAMP_W'($urandom()), SAMP_W'($urandom()));
				end
			endcase
		end
	endtask

	initial begin
		int phase;
		int target;

		arst_n       = 1'b0;
		in_valid     = 1'b0;
		left_sample  = '0;
		right_sample = '0;
		cfg_valid    = 1'b0;
		cfg_index    = CFG_INPUT_GAIN;
		cfg_data     = '0;
		cur          = settings_of(0, 64, 16, 6, 44, 44100);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part, with the sender idling now and then and the receiver
		// stalling about half of the time.
		send_gap_pct = 19;
		stall_pct    = 53;

		// The reset ratio selects the limiter, which passes words through.
		send_pair(32767, -32768);
		send_pair(-1, 0);

		// Zero ramp times give a single full step each way. A silent word with
		// the gain at unity changes nothing; the spare register indexes are
		// written with rubbish, which must leave every setting alone. A
		// makeup code of 128 drives both outputs into saturation.
		apply_settings(settings_of(128, 0, 1, 0, 0, 44100), 1'b1);
		send_pair(0, 0);
		send_pair(-32768, 32767);
		send_pair(1, -1);
		send_pair(0, 0);
		send_pair(0, 0);

		// A level exactly at the threshold is not above it; one count more is.
		// The ramp is left short of unity on purpose.
		apply_settings(settings_of(0, 64, 15, 128, 128, 192000), 1'b0);
		send_pair(16384, -16384);
		send_pair(16384, -16385);
		send_pair(-32768, -32768);
		send_pair(100, -100);

		// New settings in the middle of a release: the old step must be kept.
		// Full scale on both channels only just reaches a threshold code of 128.
		apply_settings(settings_of(64, 128, 7, 128, 128, 1), 1'b0);
		send_pair(-32768, -32768);
		send_pair(32767, 32767);

		// A sample rate of one makes the computed step far larger than the gain
		// span, so it is cut down to the span.
		apply_settings(settings_of(128, 0, 3, 1, 2, 1), 1'b0);
		send_pair(12345, -12345);
		send_pair(0, 0);

		// A sample rate of zero also gives one full step.
		apply_settings(settings_of(32, 32, 15, 5, 5, 0), 1'b0);
		send_pair(-32768, 5);
		send_pair(7, -7);

		// Bypass, then the largest ratio code, which also passes words through.
		apply_settings(settings_of(128, 0, 0, 0, 0, 44100), 1'b0);
		send_pair(-32768, 32767);
		send_pair(21845, -21846);
		apply_settings(settings_of(0, 0, 31, 0, 0, 44100), 1'b0);
		send_pair(1234, -4321);

		// Random part: bursts under a fresh setting each phase. The first third
		// runs with the sender and receiver rates as above, the second third
		// with the two swapped, and the last with no idling at all.
		for (phase = 0; phase < RANDOM_SETTINGS; phase++) begin
			if (phase == RANDOM_SETTINGS / 3) begin
				send_gap_pct = 53;
				stall_pct    = 19;
			end else if (phase == 2 * RANDOM_SETTINGS / 3) begin
				send_gap_pct = 0;
				stall_pct    = 0;
			end
			apply_settings(random_settings(), 1'b0);
			target = pairs_sent + PAIRS_PER_SETTING;
			while (pairs_sent < target) random_burst(target - pairs_sent);
		end

		// Let every result come back, then give a stray word time to appear.
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d stereo words under %0d register settings, varied idle and stall.",
			pairs_sent, setting_count);
		$display("Compared %0d results; %0d gain ramps were started, %0d mismatches found.",
			results_seen, ramp_starts, mismatch_count);
		if (mismatch_count == 0) begin
			$display("stereo_compressor_gain_ramp_top regression: pass");
		end else begin
			$display("stereo_compressor_gain_ramp_top regression: fail");
		end
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl
rtl/scgr_pkg.sv
rtl/scgr_mul.sv
rtl/scgr_div.sv
rtl/stereo_compressor_gain_ramp_top.sv
dv/scgr_compressor_checker.sv
dv/tb_stereo_compressor_gain_ramp_top.sv
